@@ src/pfe_pkg.sv @@
// shared types, constants and the monomial table of the polynomial feature expander
package pfe_pkg;

   localparam int TERM_COUNT = 35;
   localparam int MONO_COUNT = 34;
   localparam int CODE_W     = 6;

   // term code 0 is the constant term, code k+1 is monomial table entry k
   localparam logic [CODE_W-1:0] CODE_BIAS = 6'd0;

   localparam logic [1:0] CSR_MAX_DEGREE    = 2'd0;
   localparam logic [1:0] CSR_BIAS_ENABLE   = 2'd1;
   localparam logic [1:0] CSR_DISTINCT_ONLY = 2'd2;
   localparam logic [1:0] CSR_FEATURE_COUNT = 2'd3;

   // 1.0 in Q4.12
   localparam logic signed [15:0] ONE_Q12 = 16'sd4096;

   typedef struct packed {
      logic [1:0] degree;
      logic [1:0] i0;
      logic [1:0] i1;
      logic [1:0] i2;
   } mono_type;

   typedef struct packed {
      logic [1:0] max_degree;
      logic       bias_enable;
      logic       distinct_only;
      logic [2:0] feature_count;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
      logic [5:0]        number;
      logic              last;
   } term_type;

   // every monomial over four features up to degree three, in output order
   localparam mono_type MONO_TABLE [MONO_COUNT] = '{
      '{2'd1, 2'd0, 2'd0, 2'd0}, '{2'd1, 2'd1, 2'd0, 2'd0},
      '{2'd1, 2'd2, 2'd0, 2'd0}, '{2'd1, 2'd3, 2'd0, 2'd0},
      '{2'd2, 2'd0, 2'd0, 2'd0}, '{2'd2, 2'd0, 2'd1, 2'd0},
      '{2'd2, 2'd0, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd3, 2'd0},
      '{2'd2, 2'd1, 2'd1, 2'd0}, '{2'd2, 2'd1, 2'd2, 2'd0},
      '{2'd2, 2'd1, 2'd3, 2'd0}, '{2'd2, 2'd2, 2'd2, 2'd0},
      '{2'd2, 2'd2, 2'd3, 2'd0}, '{2'd2, 2'd3, 2'd3, 2'd0},
      '{2'd3, 2'd0, 2'd0, 2'd0}, '{2'd3, 2'd0, 2'd0, 2'd1},
      '{2'd3, 2'd0, 2'd0, 2'd2}, '{2'd3, 2'd0, 2'd0, 2'd3},
      '{2'd3, 2'd0, 2'd1, 2'd1}, '{2'd3, 2'd0, 2'd1, 2'd2},
      '{2'd3, 2'd0, 2'd1, 2'd3}, '{2'd3, 2'd0, 2'd2, 2'd2},
      '{2'd3, 2'd0, 2'd2, 2'd3}, '{2'd3, 2'd0, 2'd3, 2'd3},
      '{2'd3, 2'd1, 2'd1, 2'd1}, '{2'd3, 2'd1, 2'd1, 2'd2},
      '{2'd3, 2'd1, 2'd1, 2'd3}, '{2'd3, 2'd1, 2'd2, 2'd2},
      '{2'd3, 2'd1, 2'd2, 2'd3}, '{2'd3, 2'd1, 2'd3, 2'd3},
      '{2'd3, 2'd2, 2'd2, 2'd2}, '{2'd3, 2'd2, 2'd2, 2'd3},
      '{2'd3, 2'd2, 2'd3, 2'd3}, '{2'd3, 2'd3, 2'd3, 2'd3}
   };

endpackage

@@ src/pfe_sequencer.sv @@
// term sequencer: walks the enabled terms of a row, one per cycle
module pfe_sequencer #(
   parameter int MAX_FEATURES = 4,
   parameter int MAX_DEGREE   = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  pfe_pkg::cfg_type  cfg,
   input  logic              accept,
   output pfe_pkg::term_type term
);

   pfe_pkg::term_type                 term_ff;
   pfe_pkg::term_type                 term_in;
   logic [pfe_pkg::TERM_COUNT-1:0]    term_mask;
   logic [2:0]                        nf_eff;
   logic [1:0]                        deg_eff;
   logic [pfe_pkg::CODE_W-1:0]        search_from;
   logic [pfe_pkg::CODE_W-1:0]        found_code;
   logic                              found_last;
   pfe_pkg::mono_type                 mono;
   logic                              in_range;
   logic                              ordered;

   // effective feature count and degree
   always_comb begin
      if (cfg.feature_count == 3'd0) begin
         nf_eff = 3'd1;
      end else if (cfg.feature_count > 3'(MAX_FEATURES)) begin
         nf_eff = 3'(MAX_FEATURES);
      end else begin
         nf_eff = cfg.feature_count;
      end
      if (cfg.max_degree == 2'd0) begin
         deg_eff = 2'd1;
      end else if (cfg.max_degree > 2'(MAX_DEGREE)) begin
         deg_eff = 2'(MAX_DEGREE);
      end else begin
         deg_eff = cfg.max_degree;
      end
   end

   // which term codes this configuration emits
   always_comb begin
      term_mask    = '0;
      term_mask[0] = cfg.bias_enable;
      mono         = pfe_pkg::MONO_TABLE[0];
      in_range     = 1'b0;
      ordered      = 1'b0;
      for (int e = 0; e < pfe_pkg::MONO_COUNT; e++) begin
         mono     = pfe_pkg::MONO_TABLE[e];
         in_range = ({1'b0, mono.i0} < nf_eff)
                 && ((mono.degree < 2'd2) || ({1'b0, mono.i1} < nf_eff))
                 && ((mono.degree < 2'd3) || ({1'b0, mono.i2} < nf_eff));
         ordered  = ((mono.degree < 2'd2) || (mono.i1 > mono.i0))
                 && ((mono.degree < 2'd3) || (mono.i2 > mono.i1));
         term_mask[e + 1] = (mono.degree <= deg_eff) && in_range
                         && (!cfg.distinct_only || ordered);
      end
   end

   // next enabled code at or above search_from, and whether any follows it
   always_comb begin
      search_from = accept ? pfe_pkg::CODE_BIAS : term_ff.code + 6'd1;
      found_code  = pfe_pkg::CODE_BIAS;
      for (int i = pfe_pkg::TERM_COUNT - 1; i >= 0; i--) begin
         if (term_mask[i] && (6'(i) >= search_from)) begin
            found_code = 6'(i);
         end
      end
      found_last = 1'b1;
      for (int i = 0; i < pfe_pkg::TERM_COUNT; i++) begin
         if (term_mask[i] && (6'(i) > found_code)) begin
            found_last = 1'b0;
         end
      end
   end

   always_comb begin
      term_in = term_ff;
      if (accept) begin
         term_in.valid  = 1'b1;
         term_in.code   = found_code;
         term_in.number = 6'd0;
         term_in.last   = found_last;
      end else if (term_ff.valid && !term_ff.last) begin
         term_in.valid  = 1'b1;
         term_in.code   = found_code;
         term_in.number = term_ff.number + 6'd1;
         term_in.last   = found_last;
      end else begin
         term_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff <= '0;
      end else begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

@@ src/pfe_datapath.sv @@
// operand select and two-stage product pipeline of the feature expander
module pfe_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic signed [15:0]       feature_a,
   input  logic signed [15:0]       feature_b,
   input  logic signed [15:0]       feature_c,
   input  logic signed [15:0]       feature_d,
   input  pfe_pkg::term_type        term,
   output logic                     out_valid,
   output logic signed [46:0]       out_value,
   output logic [5:0]               out_number,
   output logic                     out_last
);

   logic signed [15:0] row_ff [4];

   logic               b_valid_ff;
   logic signed [15:0] b_f0_ff, b_f1_ff, b_f2_ff;
   logic signed [15:0] b_f0_in, b_f1_in, b_f2_in;
   logic [5:0]         b_number_ff;
   logic               b_last_ff;

   logic               c_valid_ff;
   logic signed [31:0] c_prod_ff;
   logic signed [15:0] c_f2_ff;
   logic [5:0]         c_number_ff;
   logic               c_last_ff;

   logic               d_valid_ff;
   logic signed [46:0] d_value_ff;
   logic signed [47:0] d_value_in;
   logic [5:0]         d_number_ff;
   logic               d_last_ff;

   pfe_pkg::mono_type  mono;

   // row holds until the next request; its last term has left stage one by then
   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff[0] <= feature_a;
         row_ff[1] <= feature_b;
         row_ff[2] <= feature_c;
         row_ff[3] <= feature_d;
      end
   end

   // unused factors are 1.0 so every term lands in Q12.36
   always_comb begin
      mono    = pfe_pkg::MONO_TABLE[0];
      b_f0_in = pfe_pkg::ONE_Q12;
      b_f1_in = pfe_pkg::ONE_Q12;
      b_f2_in = pfe_pkg::ONE_Q12;
      if ((term.code != pfe_pkg::CODE_BIAS) && (term.code <= 6'(pfe_pkg::MONO_COUNT))) begin
         mono    = pfe_pkg::MONO_TABLE[6'(term.code - 6'd1)];
         b_f0_in = row_ff[mono.i0];
         if (mono.degree >= 2'd2) begin
            b_f1_in = row_ff[mono.i1];
         end
         if (mono.degree == 2'd3) begin
            b_f2_in = row_ff[mono.i2];
         end
      end
   end

   assign d_value_in = c_prod_ff * c_f2_ff;

   always_ff @(posedge clock) begin
      b_f0_ff     <= b_f0_in;
      b_f1_ff     <= b_f1_in;
      b_f2_ff     <= b_f2_in;
      b_number_ff <= term.number;
      b_last_ff   <= term.last;

      c_prod_ff   <= b_f0_ff * b_f1_ff;
      c_f2_ff     <= b_f2_ff;
      c_number_ff <= b_number_ff;
      c_last_ff   <= b_last_ff;

      d_value_ff  <= d_value_in[46:0];
      d_number_ff <= c_number_ff;
      d_last_ff   <= c_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= term.valid;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   assign out_valid  = d_valid_ff;
   assign out_value  = d_value_ff;
   assign out_number = d_number_ff;
   assign out_last   = d_last_ff;

endmodule

@@ src/polynomial_feature_expander.sv @@
// Polynomial feature expander: a request carries one row of four signed Q4.12
// features; the block answers with one result per enabled monomial term
// (constant, linear terms, then sorted index combinations of degree two and
// three), exact in signed Q11.36, the last of the row marked by rsp_last_term.
// After a request is taken, each term of its row passes the sequencer's term
// register and the datapath's operand, product and output registers; results
// then follow one per cycle with no gaps, 1 to 35 terms per row, as the term
// sequencer issues one term per cycle. busy is high while the
// sequencer still has terms of the current row to issue; it drops on the
// cycle the last term is issued, so a new request may be taken then and its
// results follow the previous row directly. Results cannot be held off.
// Configuration writes are taken at any time but must only be made while no
// row is in flight.
module polynomial_feature_expander #(
   parameter int MAX_FEATURES = 4,
   parameter int MAX_DEGREE   = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_feature_a,
   input  logic signed [15:0] req_feature_b,
   input  logic signed [15:0] req_feature_c,
   input  logic signed [15:0] req_feature_d,
   output logic               rsp_valid,
   output logic signed [46:0] rsp_term_value,
   output logic [5:0]         rsp_term_number,
   output logic               rsp_last_term,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [2:0]         csr_wdata
);

   pfe_pkg::cfg_type  cfg_ff;
   pfe_pkg::cfg_type  cfg_in;
   pfe_pkg::term_type term;
   logic              accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            pfe_pkg::CSR_MAX_DEGREE:    cfg_in.max_degree    = csr_wdata[1:0];
            pfe_pkg::CSR_BIAS_ENABLE:   cfg_in.bias_enable   = csr_wdata[0];
            pfe_pkg::CSR_DISTINCT_ONLY: cfg_in.distinct_only = csr_wdata[0];
            pfe_pkg::CSR_FEATURE_COUNT: cfg_in.feature_count = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_degree    <= 2'd2;
         cfg_ff.bias_enable   <= 1'b1;
         cfg_ff.distinct_only <= 1'b0;
         cfg_ff.feature_count <= 3'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign busy   = term.valid && !term.last;
   assign accept = start && !busy;

   pfe_sequencer #(
      .MAX_FEATURES (MAX_FEATURES),
      .MAX_DEGREE   (MAX_DEGREE)
   ) u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (accept),
      .term   (term)
   );

   pfe_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .feature_a  (req_feature_a),
      .feature_b  (req_feature_b),
      .feature_c  (req_feature_c),
      .feature_d  (req_feature_d),
      .term       (term),
      .out_valid  (rsp_valid),
      .out_value  (rsp_term_value),
      .out_number (rsp_term_number),
      .out_last   (rsp_last_term)
   );

endmodule

@@ src/pfe_checker.sv @@
// port-level checks of the feature expander and their binding
module pfe_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [5:0] rsp_term_number,
   input logic       rsp_last_term
);

   // a taken request is answered by the first term (number zero) of its row
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 (rsp_valid && (rsp_term_number == 6'd0)))
      else $error("first term of a request missing");

   // terms of a row follow each other without gaps
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_term) |=>
         (rsp_valid && (rsp_term_number == 6'($past(rsp_term_number) + 6'd1))))
      else $error("term sequence broken");

   // after the last term comes either nothing or the start of a new row
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_term) |=> (!rsp_valid || (rsp_term_number == 6'd0)))
      else $error("term after last term of a row");

   // a row only starts in answer to a request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_term_number == 6'd0)) |-> $past(start && !busy, 4))
      else $error("row without request");

endmodule

bind polynomial_feature_expander pfe_checker u_pfe_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_term_number (rsp_term_number),
   .rsp_last_term   (rsp_last_term)
);
